### hdl/assert_macros.svh
// Assertion macros shared by the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising edge, switched off while reset is high.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property checked at every rising edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hdl/shtp_pkg.sv
package shtp_pkg;

   // Bus limits.
   localparam int MAX_TRANSFER = 1024;
   localparam int HEADER_BYTES = 4;

   // Field widths.
   localparam int ACT_W  = 3;
   localparam int TIME_W = 32;
   localparam int HDR_W  = 16;
   localparam int LEN_W  = 11;
   localparam int MLEN_W = 15;

   // Action codes on the request channel.
   localparam logic [ACT_W-1:0] ACT_IRQ       = 3'd0;
   localparam logic [ACT_W-1:0] ACT_HDR_DONE  = 3'd1;
   localparam logic [ACT_W-1:0] ACT_DATA_DONE = 3'd2;
   localparam logic [ACT_W-1:0] ACT_BUS_ERR   = 3'd3;
   localparam logic [ACT_W-1:0] ACT_QUEUE_TX  = 3'd4;

   // Status codes on the response channel.
   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_BUS_ERR = 2'd1;
   localparam logic [1:0] ST_IGNORED = 2'd2;

   // Header length word: bit 15 is a flag, all ones in the low bits means none.
   localparam logic [MLEN_W-1:0] LEN_NONE = 15'h7FFF;

   typedef enum logic [2:0] {
      EV_IRQ,
      EV_HDR_DONE,
      EV_DATA_DONE,
      EV_BUS_ERR,
      EV_QUEUE_TX,
      EV_UNKNOWN
   } ev_kind_type;

   // A classified event as it travels from the front end to the executor.
   typedef struct packed {
      ev_kind_type        kind;
      logic [TIME_W-1:0]  time_us;
      logic [MLEN_W-1:0]  rx_len;
      logic               q_zero;
      logic               q_too_long;
      logic [HDR_W-1:0]   tx_word;
   } cmd_type;

   // One response transfer.
   typedef struct packed {
      logic               start_transfer;
      logic [LEN_W-1:0]   transfer_len;
      logic               send_tx_data;
      logic               chip_select_level;
      logic               wake_level;
      logic               deliver;
      logic [LEN_W-1:0]   deliver_len;
      logic [TIME_W-1:0]  deliver_time;
      logic               tx_released;
      logic [1:0]         status;
   } rsp_type;

   // Handshake between the front end queue and the executor.
   typedef struct packed {
      logic valid;
      logic take;
   } link_type;

endpackage

### hdl/shtp_spi_transfer_sequencer.sv
// Host-side sequencer for sensor-hub SPI transactions.
// Request channel: the host presents an event (action, time_us, rx_header,
// tx_length, tx_header) and raises req_push; the event is taken at a rising
// edge with req_push high and req_full low. Actions are interrupt, header
// complete, data complete, bus error and queue transmit.
// Response channel: every event yields exactly one response, in order. It is
// on the rsp_ ports while rsp_empty is low and is taken when rsp_pop is high.
// It tells whether to start a bus transfer and its length, the chip select
// and wake levels, a delivered packet with its timestamp, transmit release
// and a status code.
// Each taken event is registered in the front-end queue, executed by the
// back end and registered in the response queue before it is on the rsp_
// ports. One event per cycle is sustained while the response queue has
// room, that is while responses are taken.
// Configuration: csr_wr_en and csr_wr_data write the DFU mode bit, which
// makes all events but zero-length queue transmits be ignored.
// Reset (synchronous, active high) empties both queues, returns to idle with
// chip select and wake deasserted, and clears DFU mode.
// When rsp_pop stays low, two responses and then two events are buffered;
// after that req_full rises until responses are taken again.
module shtp_spi_transfer_sequencer (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_push,
   output logic                          req_full,
   input  logic [shtp_pkg::ACT_W-1:0]    req_action,
   input  logic [shtp_pkg::TIME_W-1:0]   req_time_us,
   input  logic [shtp_pkg::HDR_W-1:0]    req_rx_header,
   input  logic [shtp_pkg::LEN_W-1:0]    req_tx_length,
   input  logic [shtp_pkg::HDR_W-1:0]    req_tx_header,
   output logic                          rsp_empty,
   input  logic                          rsp_pop,
   output logic                          rsp_start_transfer,
   output logic [shtp_pkg::LEN_W-1:0]    rsp_transfer_len,
   output logic                          rsp_send_tx_data,
   output logic                          rsp_chip_select_level,
   output logic                          rsp_wake_level,
   output logic                          rsp_deliver,
   output logic [shtp_pkg::LEN_W-1:0]    rsp_deliver_len,
   output logic [shtp_pkg::TIME_W-1:0]   rsp_deliver_time,
   output logic                          rsp_tx_released,
   output logic [1:0]                    rsp_status,
   input  logic                          csr_wr_en,
   input  logic                          csr_wr_data
);
   import shtp_pkg::*;

   cmd_type  cmd;
   link_type link;
   rsp_type  rsp;

   // Front end: accepts and classifies events.
   shtp_front u_front (
      .clock     (clock),
      .reset     (reset),
      .push      (req_push),
      .full      (req_full),
      .action    (req_action),
      .time_us   (req_time_us),
      .rx_header (req_rx_header),
      .tx_length (req_tx_length),
      .tx_header (req_tx_header),
      .cmd       (cmd),
      .cmd_valid (link.valid),
      .cmd_take  (link.take)
   );

   // Back end: executes events and queues the responses.
   shtp_back u_back (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .cmd         (cmd),
      .cmd_valid   (link.valid),
      .cmd_take    (link.take),
      .rsp         (rsp),
      .empty       (rsp_empty),
      .pop         (rsp_pop)
   );

   assign rsp_start_transfer    = rsp.start_transfer;
   assign rsp_transfer_len      = rsp.transfer_len;
   assign rsp_send_tx_data      = rsp.send_tx_data;
   assign rsp_chip_select_level = rsp.chip_select_level;
   assign rsp_wake_level        = rsp.wake_level;
   assign rsp_deliver           = rsp.deliver;
   assign rsp_deliver_len       = rsp.deliver_len;
   assign rsp_deliver_time      = rsp.deliver_time;
   assign rsp_tx_released       = rsp.tx_released;
   assign rsp_status            = rsp.status;

endmodule

### hdl/shtp_front.sv
module shtp_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   output logic                          full,
   input  logic [shtp_pkg::ACT_W-1:0]    action,
   input  logic [shtp_pkg::TIME_W-1:0]   time_us,
   input  logic [shtp_pkg::HDR_W-1:0]    rx_header,
   input  logic [shtp_pkg::LEN_W-1:0]    tx_length,
   input  logic [shtp_pkg::HDR_W-1:0]    tx_header,
   output shtp_pkg::cmd_type             cmd,
   output logic                          cmd_valid,
   input  logic                          cmd_take
);
   import shtp_pkg::*;

   cmd_type    slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   cmd_type    classified;
   logic       accept;

   // Classify the incoming event and pre-compute its length terms.
   always_comb begin
      classified.time_us = time_us;
      if (rx_header[MLEN_W-1:0] == LEN_NONE) begin
         classified.rx_len = '0;
      end else begin
         classified.rx_len = rx_header[MLEN_W-1:0];
      end
      classified.q_zero     = (tx_length == '0);
      classified.q_too_long = (tx_length > LEN_W'(MAX_TRANSFER));
      if (tx_length == LEN_W'(1)) begin
         classified.tx_word = {8'h00, tx_header[7:0]};
      end else begin
         classified.tx_word = tx_header;
      end
      case (action)
         ACT_IRQ:       classified.kind = EV_IRQ;
         ACT_HDR_DONE:  classified.kind = EV_HDR_DONE;
         ACT_DATA_DONE: classified.kind = EV_DATA_DONE;
         ACT_BUS_ERR:   classified.kind = EV_BUS_ERR;
         ACT_QUEUE_TX:  classified.kind = EV_QUEUE_TX;
         default:       classified.kind = EV_UNKNOWN;
      endcase
   end

   // Two-entry queue towards the executor.
   assign full      = (count_ff == 2'd2);
   assign accept    = push & ~full;
   assign cmd_valid = (count_ff != 2'd0);
   assign cmd       = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ accept;
      rd_ptr_in = rd_ptr_ff ^ cmd_take;
      count_in  = count_ff + {1'b0, accept} - {1'b0, cmd_take};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Queue storage needs no reset.
   always_ff @(posedge clock) begin
      if (accept) begin
         slot_ff[wr_ptr_ff] <= classified;
      end
   end

endmodule

### hdl/shtp_back.sv
module shtp_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_wr_en,
   input  logic                 csr_wr_data,
   input  shtp_pkg::cmd_type    cmd,
   input  logic                 cmd_valid,
   output logic                 cmd_take,
   output shtp_pkg::rsp_type    rsp,
   output logic                 empty,
   input  logic                 pop
);
   import shtp_pkg::*;

   typedef enum logic [2:0] {
      DEV_READY  = 3'b001,
      DEV_BUSY   = 3'b010,
      DEV_NEWINT = 3'b100
   } dev_state_type;

   typedef enum logic [2:0] {
      PH_IDLE = 3'b001,
      PH_DATA = 3'b010,
      PH_HDR  = 3'b100
   } phase_type;

   dev_state_type      dev_ff, dev_in;
   phase_type          phase_ff, phase_in;
   logic [TIME_W-1:0]  cur_time_ff, cur_time_in;
   logic [TIME_W-1:0]  pend_time_ff, pend_time_in;
   logic               tx_pending_ff, tx_pending_in;
   logic               tx_in_use_ff, tx_in_use_in;
   logic [HDR_W-1:0]   tx_word_ff, tx_word_in;
   logic [LEN_W-1:0]   rx_count_ff, rx_count_in;
   logic               cs_ff, cs_in;
   logic               wake_ff, wake_in;
   logic               dfu_ff;

   rsp_type            slot_ff [2];
   logic               wr_ptr_ff, rd_ptr_ff;
   logic [1:0]         count_ff, count_in;
   logic               rsp_pop;
   rsp_type            result;

   // Write the mode bit only while the block is quiet; nothing enforces it.
   always_ff @(posedge clock) begin
      if (reset) begin
         dfu_ff <= 1'b0;
      end else if (csr_wr_en) begin
         dfu_ff <= csr_wr_data;
      end
   end

   // An event is executed whenever one waits and the response queue has room.
   assign cmd_take = cmd_valid & (count_ff != 2'd2);

   // Execute one event against the transaction state.
   always_comb begin
      logic [MLEN_W-1:0] txl;
      logic [MLEN_W-1:0] wide_len;
      logic [LEN_W-1:0]  len;
      logic              do_finish;
      logic              fin_deliver;

      dev_in        = dev_ff;
      phase_in      = phase_ff;
      cur_time_in   = cur_time_ff;
      pend_time_in  = pend_time_ff;
      tx_pending_in = tx_pending_ff;
      tx_in_use_in  = tx_in_use_ff;
      tx_word_in    = tx_word_ff;
      rx_count_in   = rx_count_ff;
      cs_in         = cs_ff;
      wake_in       = wake_ff;
      result        = '0;
      result.status = ST_OK;
      do_finish     = 1'b0;
      fin_deliver   = 1'b0;

      // Larger of both header lengths, clamped to the bus maximum.
      txl = tx_in_use_ff ? tx_word_ff[MLEN_W-1:0] : '0;
      wide_len = (txl > cmd.rx_len) ? txl : cmd.rx_len;
      if (wide_len > MLEN_W'(MAX_TRANSFER)) begin
         len = LEN_W'(MAX_TRANSFER);
      end else begin
         len = wide_len[LEN_W-1:0];
      end

      case (cmd.kind)
         EV_IRQ: begin
            if (dfu_ff) begin
               result.status = ST_IGNORED;
            end else if (dev_ff == DEV_READY) begin
               dev_in       = DEV_BUSY;
               cur_time_in  = cmd.time_us;
               cs_in        = 1'b0;
               tx_in_use_in = tx_pending_ff;
               if (tx_pending_ff) begin
                  wake_in = 1'b1;
               end
               phase_in              = PH_HDR;
               rx_count_in           = LEN_W'(HEADER_BYTES);
               result.start_transfer = 1'b1;
               result.transfer_len   = LEN_W'(HEADER_BYTES);
               result.send_tx_data   = tx_pending_ff;
            end else begin
               pend_time_in = cmd.time_us;
               dev_in       = DEV_NEWINT;
            end
         end
         EV_HDR_DONE: begin
            if (dfu_ff || (phase_ff != PH_HDR)) begin
               result.status = ST_IGNORED;
            end else if (len <= LEN_W'(HEADER_BYTES)) begin
               do_finish   = 1'b1;
               fin_deliver = 1'b1;
            end else begin
               phase_in              = PH_DATA;
               rx_count_in           = len;
               result.start_transfer = 1'b1;
               result.transfer_len   = len - LEN_W'(HEADER_BYTES);
               result.send_tx_data   = tx_in_use_ff;
            end
         end
         EV_DATA_DONE: begin
            if (dfu_ff || (phase_ff != PH_DATA)) begin
               result.status = ST_IGNORED;
            end else begin
               do_finish   = 1'b1;
               fin_deliver = 1'b1;
            end
         end
         EV_BUS_ERR: begin
            if (dfu_ff || (phase_ff == PH_IDLE)) begin
               result.status = ST_IGNORED;
            end else begin
               result.status = ST_BUS_ERR;
               do_finish     = 1'b1;
            end
         end
         EV_QUEUE_TX: begin
            if (cmd.q_zero) begin
               result.status = ST_OK;
            end else if (dfu_ff || tx_pending_ff || cmd.q_too_long) begin
               result.status = ST_IGNORED;
            end else begin
               tx_word_in    = cmd.tx_word;
               tx_pending_in = 1'b1;
               wake_in       = 1'b0;
            end
         end
         default: begin
            result.status = ST_IGNORED;
         end
      endcase

      // Finish: release the bus and the transmit slot, hand up the packet (not on
      // a bus error) and restart at once if an interrupt came in meanwhile.
      if (do_finish) begin
         phase_in           = PH_IDLE;
         result.tx_released = tx_pending_ff;
         tx_pending_in      = 1'b0;
         tx_in_use_in       = 1'b0;
         cs_in              = 1'b1;
         if (fin_deliver && (rx_count_ff != '0)) begin
            result.deliver      = 1'b1;
            result.deliver_len  = rx_count_ff;
            result.deliver_time = cur_time_ff;
         end
         if (dev_ff == DEV_NEWINT) begin
            cur_time_in           = pend_time_ff;
            dev_in                = DEV_BUSY;
            cs_in                 = 1'b0;
            phase_in              = PH_HDR;
            rx_count_in           = LEN_W'(HEADER_BYTES);
            result.start_transfer = 1'b1;
            result.transfer_len   = LEN_W'(HEADER_BYTES);
            result.send_tx_data   = 1'b0;
         end else begin
            dev_in = DEV_READY;
         end
      end

      result.chip_select_level = cs_in;
      result.wake_level        = wake_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dev_ff        <= DEV_READY;
         phase_ff      <= PH_IDLE;
         cur_time_ff   <= '0;
         pend_time_ff  <= '0;
         tx_pending_ff <= 1'b0;
         tx_in_use_ff  <= 1'b0;
         tx_word_ff    <= '0;
         rx_count_ff   <= '0;
         cs_ff         <= 1'b1;
         wake_ff       <= 1'b1;
      end else if (cmd_take) begin
         dev_ff        <= dev_in;
         phase_ff      <= phase_in;
         cur_time_ff   <= cur_time_in;
         pend_time_ff  <= pend_time_in;
         tx_pending_ff <= tx_pending_in;
         tx_in_use_ff  <= tx_in_use_in;
         tx_word_ff    <= tx_word_in;
         rx_count_ff   <= rx_count_in;
         cs_ff         <= cs_in;
         wake_ff       <= wake_in;
      end
   end

   // Two-entry response queue.
   assign empty   = (count_ff == 2'd0);
   assign rsp_pop = pop & ~empty;
   assign rsp     = slot_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff + {1'b0, cmd_take} - {1'b0, rsp_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_ff ^ cmd_take;
         rd_ptr_ff <= rd_ptr_ff ^ rsp_pop;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd_take) begin
         slot_ff[wr_ptr_ff] <= result;
      end
   end

endmodule

### hdl/shtp_checker.sv
`include "assert_macros.svh"

module shtp_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_push,
   input logic                          req_full,
   input logic [shtp_pkg::ACT_W-1:0]    req_action,
   input logic [shtp_pkg::TIME_W-1:0]   req_time_us,
   input logic [shtp_pkg::HDR_W-1:0]    req_rx_header,
   input logic [shtp_pkg::LEN_W-1:0]    req_tx_length,
   input logic [shtp_pkg::HDR_W-1:0]    req_tx_header,
   input logic                          rsp_empty,
   input logic                          rsp_pop,
   input logic                          rsp_start_transfer,
   input logic [shtp_pkg::LEN_W-1:0]    rsp_transfer_len,
   input logic                          rsp_send_tx_data,
   input logic                          rsp_chip_select_level,
   input logic                          rsp_wake_level,
   input logic                          rsp_deliver,
   input logic [shtp_pkg::LEN_W-1:0]    rsp_deliver_len,
   input logic [shtp_pkg::TIME_W-1:0]   rsp_deliver_time,
   input logic                          rsp_tx_released,
   input logic [1:0]                    rsp_status,
   input logic                          csr_wr_en,
   input logic                          csr_wr_data
);

   // No response is left over from before a reset.
   `ASSERT_ALWAYS(a_empty_after_reset, clock, $past(reset) |-> rsp_empty, "response after reset")

   // A waiting response holds until it is taken.
   `ASSERT_CLK(a_rsp_hold, clock, reset, (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_deliver_len) && $stable(rsp_deliver_time)), "waiting response changed")

   // The request side only backs up behind waiting responses.
   `ASSERT_CLK(a_full_needs_rsp, clock, reset, req_full |-> !rsp_empty, "full without waiting responses")

   // A finish without restart leaves chip select deasserted.
   `ASSERT_CLK(a_cs_after_deliver, clock, reset, (!rsp_empty && rsp_deliver && !rsp_start_transfer) |-> rsp_chip_select_level, "chip select held after delivery")

endmodule

bind shtp_spi_transfer_sequencer shtp_checker u_checker (.*);

### verif/shtp_spi_transfer_sequencer_tb.sv
`timescale 1ns / 100ps

module shtp_spi_transfer_sequencer_tb;
   import shtp_pkg::*;

   // Action values that the block does not know.
   localparam logic [ACT_W-1:0] ACT_UNKNOWN_LO = 3'd5;
   localparam logic [ACT_W-1:0] ACT_UNKNOWN_HI = 3'd7;

   localparam int MAX_REPORTS = 10;
   localparam int HOLD_CYCLES = 80;

   typedef enum logic [1:0] {DEV_READY, DEV_BUSY, DEV_IRQ_PENDING} dev_state_type;
   typedef enum logic [1:0] {SEQ_IDLE, SEQ_DATA, SEQ_HEADER} seq_phase_type;

   // Transaction predictor and the store of expected responses.
   class shtp_transaction_scoreboard;
      dev_state_type     dev_state;
      seq_phase_type     phase;
      logic [TIME_W-1:0] cur_time;
      logic [TIME_W-1:0] pend_time;
      bit                tx_pending;
      bit                tx_in_use;
      bit                cs_level;
      bit                wake_level;
      bit                dfu;
      logic [HDR_W-1:0]  tx_word;
      int                rx_count;
      rsp_type           work;
      rsp_type           expected_rsps[$];
      int unsigned       errors;
      int unsigned       rsp_index;

      function new();
         dev_state  = DEV_READY;
         phase      = SEQ_IDLE;
         cur_time   = '0;
         pend_time  = '0;
         tx_pending = 1'b0;
         tx_in_use  = 1'b0;
         cs_level   = 1'b1;
         wake_level = 1'b1;
         dfu        = 1'b0;
         tx_word    = '0;
         rx_count   = 0;
         errors     = 0;
         rsp_index  = 0;
      endfunction

      function void set_dfu(bit value);
         dfu = value;
      endfunction

      function int waiting();
         return expected_rsps.size();
      endfunction

      // Chip select goes low and the header transfer starts.
      function void start_header();
         cs_level  = 1'b0;
         tx_in_use = tx_pending;
         if (tx_in_use) begin
            wake_level = 1'b1;
         end
         phase                = SEQ_HEADER;
         rx_count             = HEADER_BYTES;
         work.start_transfer  = 1'b1;
         work.transfer_len    = LEN_W'(HEADER_BYTES);
         work.send_tx_data    = tx_in_use;
      endfunction

      // Ends the transaction and restarts at once if an interrupt is waiting.
      function void end_transaction(bit with_delivery);
         phase            = SEQ_IDLE;
         work.tx_released = tx_pending;
         tx_pending       = 1'b0;
         tx_in_use        = 1'b0;
         cs_level         = 1'b1;
         if (with_delivery && rx_count != 0) begin
            work.deliver      = 1'b1;
            work.deliver_len  = LEN_W'(rx_count);
            work.deliver_time = cur_time;
         end
         if (dev_state == DEV_IRQ_PENDING) begin
            cur_time  = pend_time;
            dev_state = DEV_BUSY;
            start_header();
         end else begin
            dev_state = DEV_READY;
         end
      endfunction

      // Notes an accepted event and works out the response it causes.
      function void note_event(logic [ACT_W-1:0] act, logic [TIME_W-1:0] t_us,
                               logic [HDR_W-1:0] rxh, logic [LEN_W-1:0] tlen,
                               logic [HDR_W-1:0] txh);
         int txl;
         int rxl;
         int len;
         work        = '0;
         work.status = ST_OK;
         case (act)
            ACT_IRQ: begin
               if (dfu) begin
                  work.status = ST_IGNORED;
               end else if (dev_state == DEV_READY) begin
                  dev_state = DEV_BUSY;
                  cur_time  = t_us;
                  start_header();
               end else begin
                  pend_time = t_us;
                  dev_state = DEV_IRQ_PENDING;
               end
            end
            ACT_HDR_DONE: begin
               if (dfu || phase != SEQ_HEADER) begin
                  work.status = ST_IGNORED;
               end else begin
                  txl = tx_in_use ? int'(tx_word[MLEN_W-1:0]) : 0;
                  rxl = (rxh[MLEN_W-1:0] == LEN_NONE) ? 0 : int'(rxh[MLEN_W-1:0]);
                  len = (txl > rxl) ? txl : rxl;
                  if (len > MAX_TRANSFER) begin
                     len = MAX_TRANSFER;
                  end
                  if (len <= HEADER_BYTES) begin
                     end_transaction(1'b1);
                  end else begin
                     phase               = SEQ_DATA;
                     rx_count            = len;
                     work.start_transfer = 1'b1;
                     work.transfer_len   = LEN_W'(len - HEADER_BYTES);
                     work.send_tx_data   = tx_in_use;
                  end
               end
            end
            ACT_DATA_DONE: begin
               if (dfu || phase != SEQ_DATA) begin
                  work.status = ST_IGNORED;
               end else begin
                  end_transaction(1'b1);
               end
            end
            ACT_BUS_ERR: begin
               if (dfu || phase == SEQ_IDLE) begin
                  work.status = ST_IGNORED;
               end else begin
                  work.status = ST_BUS_ERR;
                  end_transaction(1'b0);
               end
            end
            ACT_QUEUE_TX: begin
               if (tlen == '0) begin
                  work.status = ST_OK;
               end else if (dfu || tx_pending || int'(tlen) > MAX_TRANSFER) begin
                  work.status = ST_IGNORED;
               end else begin
                  tx_word    = (tlen == LEN_W'(1)) ? {8'h00, txh[7:0]} : txh;
                  tx_pending = 1'b1;
                  wake_level = 1'b0;
               end
            end
            default: begin
               work.status = ST_IGNORED;
            end
         endcase
         work.chip_select_level = cs_level;
         work.wake_level        = wake_level;
         expected_rsps.push_back(work);
      endfunction

      function void check_field(string name, logic [31:0] want, logic [31:0] seen);
         if (seen !== want) begin
            errors++;
            if (errors <= MAX_REPORTS) begin
               $display("%0t ns: response %0d, %s expected 0x%0h, got 0x%0h",
                        $time, rsp_index, name, want, seen);
            end
         end
      endfunction

      // Compares a response transfer with the oldest expectation.
      function void check_response(rsp_type seen);
         rsp_type want;
         if (expected_rsps.size() == 0) begin
            errors++;
            if (errors <= MAX_REPORTS) begin
               $display("%0t ns: response transfer with no expectation waiting", $time);
            end
            return;
         end
         want = expected_rsps.pop_front();
         check_field("start_transfer", want.start_transfer, seen.start_transfer);
         check_field("transfer_len", want.transfer_len, seen.transfer_len);
         check_field("send_tx_data", want.send_tx_data, seen.send_tx_data);
         check_field("chip_select_level", want.chip_select_level, seen.chip_select_level);
         check_field("wake_level", want.wake_level, seen.wake_level);
         check_field("deliver", want.deliver, seen.deliver);
         check_field("deliver_len", want.deliver_len, seen.deliver_len);
         check_field("deliver_time", want.deliver_time, seen.deliver_time);
         check_field("tx_released", want.tx_released, seen.tx_released);
         check_field("status", want.status, seen.status);
         rsp_index++;
      endfunction
   endclass

   logic                clock;
   logic                reset;
   logic                req_push;
   logic                req_full;
   logic [ACT_W-1:0]    req_action;
   logic [TIME_W-1:0]   req_time_us;
   logic [HDR_W-1:0]    req_rx_header;
   logic [LEN_W-1:0]    req_tx_length;
   logic [HDR_W-1:0]    req_tx_header;
   logic                rsp_empty;
   logic                rsp_pop;
   logic                rsp_start_transfer;
   logic [LEN_W-1:0]    rsp_transfer_len;
   logic                rsp_send_tx_data;
   logic                rsp_chip_select_level;
   logic                rsp_wake_level;
   logic                rsp_deliver;
   logic [LEN_W-1:0]    rsp_deliver_len;
   logic [TIME_W-1:0]   rsp_deliver_time;
   logic                rsp_tx_released;
   logic [1:0]          rsp_status;
   logic                csr_wr_en;
   logic                csr_wr_data;
   rsp_type             seen_rsp;

   shtp_transaction_scoreboard sb = new();
   int unsigned n_items = 0;
   bit          no_idle = 1'b0;
   bit          hold_rsp = 1'b0;

   shtp_spi_transfer_sequencer i_dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_push              (req_push),
      .req_full              (req_full),
      .req_action            (req_action),
      .req_time_us           (req_time_us),
      .req_rx_header         (req_rx_header),
      .req_tx_length         (req_tx_length),
      .req_tx_header         (req_tx_header),
      .rsp_empty             (rsp_empty),
      .rsp_pop               (rsp_pop),
      .rsp_start_transfer    (rsp_start_transfer),
      .rsp_transfer_len      (rsp_transfer_len),
      .rsp_send_tx_data      (rsp_send_tx_data),
      .rsp_chip_select_level (rsp_chip_select_level),
      .rsp_wake_level        (rsp_wake_level),
      .rsp_deliver           (rsp_deliver),
      .rsp_deliver_len       (rsp_deliver_len),
      .rsp_deliver_time      (rsp_deliver_time),
      .rsp_tx_released       (rsp_tx_released),
      .rsp_status            (rsp_status),
      .csr_wr_en             (csr_wr_en),
      .csr_wr_data           (csr_wr_data)
   );

   assign seen_rsp = {rsp_start_transfer, rsp_transfer_len, rsp_send_tx_data,
                      rsp_chip_select_level, rsp_wake_level, rsp_deliver,
                      rsp_deliver_len, rsp_deliver_time, rsp_tx_released, rsp_status};

   // Clock with an 8 ns period.
   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   // Register writes, accepted events and response transfers seen at the rising edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_wr_en) begin
            sb.set_dfu(csr_wr_data);
         end
         if (req_push && !req_full) begin
            sb.note_event(req_action, req_time_us, req_rx_header, req_tx_length,
                          req_tx_header);
         end
         if (rsp_pop && !rsp_empty) begin
            sb.check_response(seen_rsp);
         end
      end
   end

   // Mostly short gaps, now and then a long one.
   function automatic int unsigned idle_len();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 50) begin
         return 0;
      end else if (r < 90) begin
         return $urandom_range(1, 3);
      end else if (r < 98) begin
         return $urandom_range(4, 12);
      end
      return $urandom_range(20, 60);
   endfunction

   // Receiver: random idling, and a long hold-off when asked for.
   initial begin
      int unsigned pop_gap;
      pop_gap = 0;
      rsp_pop = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_rsp) begin
            rsp_pop = 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_rsp = 1'b0;
         end else if (pop_gap != 0) begin
            rsp_pop = 1'b0;
            pop_gap--;
         end else begin
            rsp_pop = 1'b1;
            pop_gap = no_idle ? 0 : idle_len();
         end
      end
   end

   // Offers one event and waits for its transfer; called at a falling edge.
   task automatic push_event(input logic [ACT_W-1:0] act, input logic [TIME_W-1:0] t_us,
                             input logic [HDR_W-1:0] rxh, input logic [LEN_W-1:0] tlen,
                             input logic [HDR_W-1:0] txh);
      int unsigned gap;
      req_action    = act;
      req_time_us   = t_us;
      req_rx_header = rxh;
      req_tx_length = tlen;
      req_tx_header = txh;
      req_push      = 1'b1;
      @(posedge clock);
      while (req_full) @(posedge clock);
      n_items++;
      @(negedge clock);
      gap = no_idle ? 0 : idle_len();
      if (gap != 0) begin
         req_push = 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   // Stops offering and waits until every expected response has arrived.
   task automatic drain();
      req_push = 1'b0;
      while (sb.waiting() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_dfu(input bit value);
      drain();
      csr_wr_en   = 1'b1;
      csr_wr_data = value;
      @(negedge clock);
      csr_wr_en   = 1'b0;
   endtask

   task automatic send_irq();
      push_event(ACT_IRQ, $urandom, HDR_W'($urandom), LEN_W'($urandom), HDR_W'($urandom));
   endtask

   task automatic simple_event(input logic [ACT_W-1:0] act);
      push_event(act, $urandom, HDR_W'($urandom), LEN_W'($urandom), HDR_W'($urandom));
   endtask

   // Header complete with a length word drawn from the interesting classes.
   task automatic send_header();
      logic [HDR_W-1:0] rxh;
      case ($urandom_range(0, 6))
         0: rxh = 16'h0000;
         1: rxh = {1'b0, LEN_NONE};
         2: rxh = 16'hFFFF;
         3: rxh = {1'($urandom), 15'($urandom_range(1, HEADER_BYTES))};
         4: rxh = {1'($urandom), 15'($urandom_range(HEADER_BYTES + 1, 64))};
         5: rxh = {1'($urandom), 15'($urandom_range(65, MAX_TRANSFER))};
         default: rxh = HDR_W'($urandom);
      endcase
      push_event(ACT_HDR_DONE, $urandom, rxh, LEN_W'($urandom), HDR_W'($urandom));
   endtask

   task automatic queue_random();
      logic [LEN_W-1:0] tlen;
      logic [HDR_W-1:0] txh;
      case ($urandom_range(0, 9))
         0: tlen = '0;
         1: tlen = LEN_W'(1);
         2: tlen = LEN_W'(MAX_TRANSFER);
         3: tlen = LEN_W'($urandom_range(MAX_TRANSFER + 1, 2047));
         4, 5: tlen = LEN_W'($urandom_range(2, 64));
         default: tlen = LEN_W'($urandom_range(1, MAX_TRANSFER));
      endcase
      if ($urandom_range(0, 1)) begin
         txh = {1'($urandom), 15'($urandom_range(0, 80))};
      end else begin
         txh = HDR_W'($urandom);
      end
      push_event(ACT_QUEUE_TX, $urandom, HDR_W'($urandom), tlen, txh);
   endtask

   task automatic send_noise();
      push_event(ACT_W'($urandom_range(0, 7)), $urandom, HDR_W'($urandom),
                 LEN_W'($urandom_range(0, 2047)), HDR_W'($urandom));
   endtask

   // A well-formed transaction with random content and occasional disturbance.
   task automatic run_transaction();
      int unsigned steps;
      int unsigned r;
      if ($urandom_range(0, 1)) begin
         queue_random();
      end
      send_irq();
      steps = 0;
      while (sb.phase != SEQ_IDLE && steps < 10) begin
         r = $urandom_range(0, 99);
         if (r < 8) begin
            send_irq();
         end else if (r < 14) begin
            queue_random();
         end else if (r < 20) begin
            simple_event(ACT_BUS_ERR);
         end else if (sb.phase == SEQ_HEADER) begin
            send_header();
         end else begin
            simple_event(ACT_DATA_DONE);
         end
         steps++;
      end
   endtask

   task automatic random_traffic(input int unsigned until_items);
      while (n_items < until_items) begin
         if ($urandom_range(0, 99) < 15) begin
            send_noise();
         end else begin
            run_transaction();
         end
      end
   endtask

   // Run limit.
   initial begin
      #5_000_000;
      $display("CHECK FAILED");
      $finish;
   end

   // Stimulus.
   initial begin
      reset         = 1'b1;
      req_push      = 1'b0;
      req_action    = ACT_IRQ;
      req_time_us   = '0;
      req_rx_header = '0;
      req_tx_length = '0;
      req_tx_header = '0;
      csr_wr_en     = 1'b0;
      csr_wr_data   = 1'b0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      write_dfu(1'b0);

      // Events out of place, unknown actions, a zero-length and refused queue requests.
      push_event(ACT_HDR_DONE, '0, 16'hFFFF, '0, '0);
      push_event(ACT_DATA_DONE, '0, '0, '0, '0);
      push_event(ACT_BUS_ERR, '0, '0, '0, '0);
      push_event(ACT_UNKNOWN_LO, '0, '0, '0, '0);
      push_event(ACT_UNKNOWN_HI, 32'hFFFF_FFFF, 16'hFFFF, 11'h7FF, 16'hFFFF);
      push_event(ACT_QUEUE_TX, '0, '0, '0, 16'hFFFF);
      push_event(ACT_QUEUE_TX, '0, '0, 11'h7FF, 16'hFFFF);
      // One-byte packet, then a second queue request that must be refused.
      push_event(ACT_QUEUE_TX, '0, '0, LEN_W'(1), 16'hFFFF);
      push_event(ACT_QUEUE_TX, '0, '0, LEN_W'(8), 16'h0008);
      // Interrupt while busy, then a restart from the data finish.
      push_event(ACT_IRQ, 32'hFFFF_FFFF, '0, '0, '0);
      push_event(ACT_IRQ, 32'h1234_5678, '0, '0, '0);
      push_event(ACT_DATA_DONE, '0, '0, '0, '0);
      push_event(ACT_HDR_DONE, '0, {1'b0, LEN_NONE}, '0, '0);
      push_event(ACT_HDR_DONE, '0, 16'h0010, '0, '0);
      push_event(ACT_DATA_DONE, '0, '0, '0, '0);
      // Short length with bit 15 set, then zero length by the all-ones none marker.
      push_event(ACT_HDR_DONE, '0, 16'h8004, '0, '0);
      push_event(ACT_IRQ, '0, '0, '0, '0);
      push_event(ACT_HDR_DONE, '0, 16'hFFFF, '0, '0);
      // Longest packet with a length word above the limit, ended by a bus error.
      push_event(ACT_QUEUE_TX, '0, '0, LEN_W'(MAX_TRANSFER), 16'hFFFF);
      push_event(ACT_IRQ, 32'h0000_0001, '0, '0, '0);
      push_event(ACT_HDR_DONE, '0, 16'h0000, '0, '0);
      push_event(ACT_BUS_ERR, '0, '0, '0, '0);
      // Transmit queued mid-transaction is dropped by the finish.
      push_event(ACT_IRQ, 32'hAAAA_5555, '0, '0, '0);
      push_event(ACT_QUEUE_TX, '0, '0, LEN_W'(5), 16'h0005);
      push_event(ACT_HDR_DONE, '0, 16'h0005, '0, '0);
      push_event(ACT_DATA_DONE, '0, '0, '0, '0);

      // DFU mode ignores everything but zero-length queue requests.
      write_dfu(1'b1);
      push_event(ACT_IRQ, 32'h5555_AAAA, '0, '0, '0);
      push_event(ACT_HDR_DONE, '0, 16'h0100, '0, '0);
      push_event(ACT_DATA_DONE, '0, '0, '0, '0);
      push_event(ACT_BUS_ERR, '0, '0, '0, '0);
      push_event(ACT_QUEUE_TX, '0, '0, LEN_W'(4), 16'h0004);
      write_dfu(1'b0);

      // Random traffic, with a stretch of full rate during which the receiver holds off.
      random_traffic(330);
      no_idle  = 1'b1;
      hold_rsp = 1'b1;
      random_traffic(420);
      no_idle  = 1'b0;
      random_traffic(560);
      write_dfu(1'b1);
      random_traffic(620);
      write_dfu(1'b0);
      random_traffic(850);
      no_idle = 1'b1;
      random_traffic(950);
      hold_rsp = 1'b1;
      no_idle  = 1'b0;
      random_traffic(1145);

      drain();
      if (sb.errors == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

### sim.f
+incdir+hdl
hdl/shtp_pkg.sv
hdl/shtp_front.sv
hdl/shtp_back.sv
hdl/shtp_spi_transfer_sequencer.sv
hdl/shtp_checker.sv
verif/shtp_spi_transfer_sequencer_tb.sv
